// ----- design/fuzzy_temperature_controller_macros.svh -----
// Assertion macros for the fuzzy temperature controller.
// Used by the top level; expects clk and arst_n in the including scope.
`ifndef FUZZY_TEMPERATURE_CONTROLLER_MACROS_SVH
`define FUZZY_TEMPERATURE_CONTROLLER_MACROS_SVH
`ifndef SYNTH
// same-cycle implication
`define FTC_ASSERT_SAME(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ftc: same-cycle check failed");
// next-cycle implication
`define FTC_ASSERT_NEXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ftc: next-cycle check failed");
`else
`define FTC_ASSERT_SAME(name, ante, cons)
`define FTC_ASSERT_NEXT(name, ante, cons)
`endif
`endif

// ----- design/ftc_pkg.sv -----
// Shared types and constants of the fuzzy temperature controller.
// No dependencies; used by every module of the block but ftc_div_pipe.
package ftc_pkg;

	localparam int TEMP_W     = 12;
	localparam int CTR_W      = 11;
	localparam int ERR_W      = 13;
	localparam int DIST_W     = ERR_W;
	localparam int DRIVE_W    = 11;
	localparam int DIR_W      = 2;
	localparam int N_SETS     = 3;
	localparam int SET_NEG    = 0;
	localparam int SET_ZERO   = 1;
	localparam int SET_POS    = 2;
	localparam int QUEUE_DEPTH = 2;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 12;

	localparam int IN_TDATA_W  = ((TEMP_W + 7) / 8) * 8;
	localparam int OUT_TDATA_W = ((DRIVE_W + DIR_W + 7) / 8) * 8;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_SETPOINT    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ERROR_LOW   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ERROR_MID   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ERROR_HIGH  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_CENTER_COOL = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_CENTER_OFF  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_CENTER_HEAT = 3'd6;

	// direction codes
	localparam logic [DIR_W-1:0] DIR_IDLE = 2'd0;
	localparam logic [DIR_W-1:0] DIR_COOL = 2'd1;
	localparam logic [DIR_W-1:0] DIR_HEAT = 2'd2;

	// reset values; temperatures in whole degrees, scaled at the top level
	localparam int RST_SETPOINT_DEG = 22;
	localparam int RST_ERR_DEG      = 10;
	localparam logic signed [CTR_W-1:0] RST_CENTER_COOL = -11'sd1000;
	localparam logic signed [CTR_W-1:0] RST_CENTER_OFF  = 11'sd0;
	localparam logic signed [CTR_W-1:0] RST_CENTER_HEAT = 11'sd1000;

	typedef struct packed {
		logic signed [TEMP_W-1:0] setpoint;
		logic signed [TEMP_W-1:0] error_low;
		logic signed [TEMP_W-1:0] error_mid;
		logic signed [TEMP_W-1:0] error_high;
		logic signed [CTR_W-1:0]  center_cool;
		logic signed [CTR_W-1:0]  center_off;
		logic signed [CTR_W-1:0]  center_heat;
	} cfg_t;

	// one division job per fuzzy set: delta / span, delta <= span
	typedef struct packed {
		logic [N_SETS-1:0][DIST_W-1:0] delta;
		logic [N_SETS-1:0][DIST_W-1:0] span;
	} q_entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

endpackage

// ----- design/fuzzy_temperature_controller.sv -----
// One beat per cycle unless m_tready stalls, set by the one-bit-per-stage divider pipelines.
// A two-entry queue separates the error front end from the division back end.
// Reset (arst_n low, async): config registers load defaults, all valid bits clear.
// No clearing pass; the block takes beats on the first cycle after reset.
// Depends on ftc_pkg, ftc_front, ftc_queue, ftc_back and the macro header.
`include "fuzzy_temperature_controller_macros.svh"
module fuzzy_temperature_controller #(
	parameter int MEMBERSHIP_BITS = 12,
	parameter int TEMP_FRAC_BITS  = 4
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// input stream
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [ftc_pkg::IN_TDATA_W-1:0]      s_tdata,   // [11:0] measured_temp
	// output stream
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [ftc_pkg::OUT_TDATA_W-1:0]     m_tdata,   // [10:0] drive_power, [12:11] direction
	// register writes
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [ftc_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [ftc_pkg::CFG_DATA_W-1:0]      cfg_data
);

	localparam int TW      = ftc_pkg::TEMP_W;
	localparam int CW      = ftc_pkg::CTR_W;
	localparam int OUT_PAD = ftc_pkg::OUT_TDATA_W - ftc_pkg::DRIVE_W - ftc_pkg::DIR_W;

	// temperature defaults scale with the number of fraction bits, then wrap
	localparam int SP_RST_I = ftc_pkg::RST_SETPOINT_DEG << TEMP_FRAC_BITS;
	localparam int EH_RST_I = ftc_pkg::RST_ERR_DEG << TEMP_FRAC_BITS;
	localparam int EL_RST_I = -EH_RST_I;
	localparam logic [TW-1:0] SP_RST = SP_RST_I[TW-1:0];
	localparam logic [TW-1:0] EH_RST = EH_RST_I[TW-1:0];
	localparam logic [TW-1:0] EL_RST = EL_RST_I[TW-1:0];

	ftc_pkg::cfg_t       cfg_q;
	ftc_pkg::q_entry_t   q_wr_data;
	ftc_pkg::q_entry_t   q_rd_data;
	ftc_pkg::q_status_t  q_st;
	logic                q_push;
	logic                q_pop;
	logic signed [ftc_pkg::DRIVE_W-1:0] drive;
	logic [ftc_pkg::DIR_W-1:0]          dir;

	// Register file. Always ready; writes beyond the last index are dropped.
	// Centers keep the low 11 bits of the written word.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.setpoint    <= SP_RST;
			cfg_q.error_low   <= EL_RST;
			cfg_q.error_mid   <= '0;
			cfg_q.error_high  <= EH_RST;
			cfg_q.center_cool <= ftc_pkg::RST_CENTER_COOL;
			cfg_q.center_off  <= ftc_pkg::RST_CENTER_OFF;
			cfg_q.center_heat <= ftc_pkg::RST_CENTER_HEAT;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				ftc_pkg::REG_SETPOINT:    cfg_q.setpoint    <= cfg_data;
				ftc_pkg::REG_ERROR_LOW:   cfg_q.error_low   <= cfg_data;
				ftc_pkg::REG_ERROR_MID:   cfg_q.error_mid   <= cfg_data;
				ftc_pkg::REG_ERROR_HIGH:  cfg_q.error_high  <= cfg_data;
				ftc_pkg::REG_CENTER_COOL: cfg_q.center_cool <= cfg_data[CW-1:0];
				ftc_pkg::REG_CENTER_OFF:  cfg_q.center_off  <= cfg_data[CW-1:0];
				ftc_pkg::REG_CENTER_HEAT: cfg_q.center_heat <= cfg_data[CW-1:0];
				default: ;
			endcase
		end
	end

	// Front: error, clamp, and per-set edge selection. Stalls only on a full queue.
	ftc_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_temp  (s_tdata[TW-1:0]),
		.q_st     (q_st),
		.q_push   (q_push),
		.q_data   (q_wr_data)
	);

	ftc_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (q_push),
		.wr_data (q_wr_data),
		.pop     (q_pop),
		.rd_data (q_rd_data),
		.st      (q_st)
	);

	// Back: three membership divisions in parallel lanes, weighting,
	// then a rounded average division feeding the output register.
	ftc_back #(
		.MEMBERSHIP_BITS (MEMBERSHIP_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_st      (q_st),
		.q_data    (q_rd_data),
		.q_pop     (q_pop),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_drive (drive),
		.out_dir   (dir)
	);

	assign m_tdata = {{OUT_PAD{1'b0}}, dir, drive};

	`FTC_ASSERT_SAME(a_queue_no_overflow, q_st.full, !q_push)
	`FTC_ASSERT_SAME(a_queue_no_underflow, q_st.empty, !q_pop)
	`FTC_ASSERT_NEXT(a_queue_push_fills, q_push && !q_pop, !q_st.empty)
	`FTC_ASSERT_SAME(a_dir_follows_drive, m_tvalid, (dir == ftc_pkg::DIR_IDLE) == (drive == '0))

endmodule

// ----- design/ftc_div_pipe.sv -----
// Pipelined restoring divider, one quotient bit per stage, several lanes.
// Requires in_num < in_den * 2**QUO_W. Uses no package items.
module ftc_div_pipe #(
	parameter int LANES = 1,
	parameter int NUM_W = 16,
	parameter int DEN_W = 8,
	parameter int QUO_W = 8
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  logic                         in_valid,
	input  logic [LANES-1:0][NUM_W-1:0]  in_num,
	input  logic [LANES-1:0][DEN_W-1:0]  in_den,
	output logic                         out_valid,
	output logic [LANES-1:0][QUO_W-1:0]  out_quo
);

	localparam int EXT_W = NUM_W + DEN_W + 1;

	logic             vld_s [QUO_W];
	logic [DEN_W:0]   rem_s [QUO_W][LANES];
	logic [QUO_W-1:0] low_s [QUO_W][LANES];
	logic [QUO_W-1:0] quo_s [QUO_W][LANES];
	logic [DEN_W-1:0] den_s [QUO_W][LANES];

	for (genvar k = 0; k < QUO_W; k++) begin : g_stage
		if (k == 0) begin : g_vfirst
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n)
					vld_s[k] <= 1'b0;
				else if (en)
					vld_s[k] <= in_valid;
			end
		end else begin : g_vnext
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n)
					vld_s[k] <= 1'b0;
				else if (en)
					vld_s[k] <= vld_s[k-1];
			end
		end

		for (genvar l = 0; l < LANES; l++) begin : g_lane
			logic [DEN_W:0]   rem_in;
			logic [QUO_W-1:0] low_in;
			logic [QUO_W-1:0] quo_in;
			logic [DEN_W-1:0] den_in;
			logic [DEN_W:0]   trial;
			logic             ge;

			if (k == 0) begin : g_src_in
				logic [EXT_W-1:0] ext;
				// partial remainder starts as the dividend bits above the quotient
				assign ext    = EXT_W'(in_num[l]);
				assign rem_in = ext[QUO_W +: DEN_W+1];
				assign low_in = in_num[l][QUO_W-1:0];
				assign den_in = in_den[l];
				assign quo_in = '0;
			end else begin : g_src_prev
				assign rem_in = rem_s[k-1][l];
				assign low_in = low_s[k-1][l];
				assign den_in = den_s[k-1][l];
				assign quo_in = quo_s[k-1][l];
			end

			assign trial = {rem_in[DEN_W-1:0], low_in[QUO_W-1-k]};
			assign ge    = trial >= {1'b0, den_in};

			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[k][l] <= ge ? trial - {1'b0, den_in} : trial;
					low_s[k][l] <= low_in;
					den_s[k][l] <= den_in;
					quo_s[k][l] <= {quo_in[QUO_W-2:0], ge};
				end
			end

			if (k == QUO_W - 1) begin : g_out
				assign out_quo[l] = quo_s[k][l];
			end
		end
	end

	assign out_valid = vld_s[QUO_W-1];

endmodule

// ----- design/ftc_queue.sv -----
// Short register queue between the front and back halves.
// Depends on ftc_pkg (entry and status types, depth).
module ftc_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  ftc_pkg::q_entry_t   wr_data,
	input  logic                pop,
	output ftc_pkg::q_entry_t   rd_data,
	output ftc_pkg::q_status_t  st
);

	localparam int DEPTH = ftc_pkg::QUEUE_DEPTH;
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);
	localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

	ftc_pkg::q_entry_t ent_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  cnt_q;

	function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
		return (p == LAST) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= next_ptr(wr_ptr_q);
			if (pop)
				rd_ptr_q <= next_ptr(rd_ptr_q);
			if (push && !pop)
				cnt_q <= cnt_q + CNT_ONE;
			else if (pop && !push)
				cnt_q <= cnt_q - CNT_ONE;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			ent_q[wr_ptr_q] <= wr_data;
	end

	assign rd_data  = ent_q[rd_ptr_q];
	assign st.full  = cnt_q == FULL_CNT;
	assign st.empty = cnt_q == '0;

endmodule

// ----- design/ftc_front.sv -----
// Front half: takes a temperature beat, forms and clamps the error and
// sets up one division job per fuzzy set. Depends on ftc_pkg.
module ftc_front (
	input  logic                                clk,
	input  logic                                arst_n,
	input  ftc_pkg::cfg_t                       cfg,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [ftc_pkg::TEMP_W-1:0]          in_temp,
	input  ftc_pkg::q_status_t                  q_st,
	output logic                                q_push,
	output ftc_pkg::q_entry_t                   q_data
);

	localparam int TW = ftc_pkg::TEMP_W;
	localparam int EW = ftc_pkg::ERR_W;
	localparam int DW = ftc_pkg::DIST_W;
	localparam logic signed [EW-1:0] ONE_E = EW'(1);
	localparam logic [DW-1:0] ONE_D = DW'(1);

	function automatic logic signed [EW-1:0] widen(input logic [TW-1:0] v);
		return $signed({{(EW-TW){v[TW-1]}}, v});
	endfunction

	logic                   v_s1;
	logic signed [EW-1:0]   err_s1;
	logic signed [EW-1:0]   lo;
	logic signed [EW-1:0]   mid;
	logic signed [EW-1:0]   hi;
	logic signed [EW-1:0]   ec1;
	logic signed [EW-1:0]   ec;

	assign in_ready = !v_s1 || !q_st.full;
	assign q_push   = v_s1 && !q_st.full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else if (in_ready)
			v_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready)
			err_s1 <= widen(cfg.setpoint) - widen(in_temp);
	end

	always_comb begin
		lo  = widen(cfg.error_low);
		mid = widen(cfg.error_mid);
		hi  = widen(cfg.error_high);

		// low bound first, high bound second, even if misordered
		ec1 = (err_s1 <= lo) ? lo + ONE_E : err_s1;
		ec  = (ec1 >= hi) ? hi - ONE_E : ec1;

		// inactive edge: 0 / 1 gives zero membership
		for (int k = 0; k < ftc_pkg::N_SETS; k++) begin
			q_data.delta[k] = '0;
			q_data.span[k]  = ONE_D;
		end

		// negative set: falling edge from low to mid
		if (ec > lo && ec < mid) begin
			q_data.delta[ftc_pkg::SET_NEG] = mid - ec;
			q_data.span[ftc_pkg::SET_NEG]  = mid - lo;
		end

		// zero set: rising low..mid, falling mid..high
		if (ec > lo) begin
			if (ec <= mid) begin
				q_data.delta[ftc_pkg::SET_ZERO] = ec - lo;
				q_data.span[ftc_pkg::SET_ZERO]  = mid - lo;
			end else if (ec < hi) begin
				q_data.delta[ftc_pkg::SET_ZERO] = hi - ec;
				q_data.span[ftc_pkg::SET_ZERO]  = hi - mid;
			end
		end

		// positive set: rising edge from mid to high
		if (ec > mid && ec <= hi) begin
			q_data.delta[ftc_pkg::SET_POS] = ec - mid;
			q_data.span[ftc_pkg::SET_POS]  = hi - mid;
		end
	end

endmodule

// ----- design/ftc_back.sv -----
// Back half: membership division, weighting, rounded average and the
// output register. Depends on ftc_pkg and ftc_div_pipe.
module ftc_back #(
	parameter int MEMBERSHIP_BITS = 12
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  ftc_pkg::cfg_t                       cfg,
	input  ftc_pkg::q_status_t                  q_st,
	input  ftc_pkg::q_entry_t                   q_data,
	output logic                                q_pop,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [ftc_pkg::DRIVE_W-1:0]  out_drive,
	output logic [ftc_pkg::DIR_W-1:0]           out_dir
);

	localparam int NS     = ftc_pkg::N_SETS;
	localparam int DW     = ftc_pkg::DIST_W;
	localparam int CW     = ftc_pkg::CTR_W;
	localparam int QD     = ftc_pkg::DRIVE_W;
	localparam int W_W    = MEMBERSHIP_BITS + 1;
	localparam int MNUM_W = DW + MEMBERSHIP_BITS;
	localparam int PROD_W = W_W + CW + 1;
	localparam int NUM_W  = PROD_W + 2;
	localparam int DEN_W  = MEMBERSHIP_BITS + 2;
	localparam int DVD_W  = NUM_W + 1;
	localparam logic [DEN_W-1:0] ONE_DEN = DEN_W'(1);

	logic                          en;
	logic [NS-1:0][MNUM_W-1:0]     mem_num;
	logic                          w_valid;
	logic [NS-1:0][W_W-1:0]        w_quo;
	logic signed [CW-1:0]          ctr [NS];

	logic signed [PROD_W-1:0]      wx [NS];
	logic signed [PROD_W-1:0]      cx [NS];
	logic signed [PROD_W-1:0]      prod_c [NS];

	logic                          v_s1, v_s2, v_s3, v_s4;
	logic signed [PROD_W-1:0]      prod_s1 [NS];
	logic [W_W-1:0]                w_s1 [NS];
	logic signed [NUM_W-1:0]       num_s2;
	logic [DEN_W-1:0]              den_s2;
	logic                          neg_s3;
	logic [NUM_W-1:0]              mag_s3;
	logic [DEN_W-1:0]              den_s3;
	logic                          neg_s4;
	logic [DVD_W-1:0]              dvd_s4;
	logic [DEN_W-1:0]              den_s4;

	logic                          q_valid;
	logic [QD-1:0]                 quo_d;
	logic                          neg_d [QD];

	logic                          valid_q;
	logic signed [QD-1:0]          drive_q;
	logic [ftc_pkg::DIR_W-1:0]     dir_q;
	logic signed [QD-1:0]          drive_c;
	logic [ftc_pkg::DIR_W-1:0]     dir_c;

	// whole back pipeline moves when the output slot is free
	assign en    = !valid_q || out_ready;
	assign q_pop = en && !q_st.empty;

	always_comb begin
		for (int l = 0; l < NS; l++)
			mem_num[l] = {q_data.delta[l], {MEMBERSHIP_BITS{1'b0}}};
	end

	ftc_div_pipe #(
		.LANES (NS),
		.NUM_W (MNUM_W),
		.DEN_W (DW),
		.QUO_W (W_W)
	) u_mem_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (!q_st.empty),
		.in_num    (mem_num),
		.in_den    (q_data.span),
		.out_valid (w_valid),
		.out_quo   (w_quo)
	);

	assign ctr[ftc_pkg::SET_NEG]  = cfg.center_cool;
	assign ctr[ftc_pkg::SET_ZERO] = cfg.center_off;
	assign ctr[ftc_pkg::SET_POS]  = cfg.center_heat;

	always_comb begin
		for (int l = 0; l < NS; l++) begin
			wx[l]     = $signed({{(PROD_W-W_W){1'b0}}, w_quo[l]});
			cx[l]     = $signed({{(PROD_W-CW){ctr[l][CW-1]}}, ctr[l]});
			prod_c[l] = wx[l] * cx[l];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= w_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < NS; l++) begin
				prod_s1[l] <= prod_c[l];
				w_s1[l]    <= w_quo[l];
			end

			num_s2 <= {{(NUM_W-PROD_W){prod_s1[0][PROD_W-1]}}, prod_s1[0]}
				+ {{(NUM_W-PROD_W){prod_s1[1][PROD_W-1]}}, prod_s1[1]}
				+ {{(NUM_W-PROD_W){prod_s1[2][PROD_W-1]}}, prod_s1[2]};
			den_s2 <= DEN_W'(w_s1[0]) + DEN_W'(w_s1[1]) + DEN_W'(w_s1[2]);

			// all-zero weights give num 0; divide 0 by 1
			neg_s3 <= num_s2[NUM_W-1];
			mag_s3 <= num_s2[NUM_W-1] ? -num_s2 : num_s2;
			den_s3 <= (den_s2 == '0) ? ONE_DEN : den_s2;

			// half the divisor added: round to nearest, ties away from zero
			neg_s4 <= neg_s3;
			dvd_s4 <= DVD_W'(mag_s3) + DVD_W'(den_s3 >> 1);
			den_s4 <= den_s3;
		end
	end

	ftc_div_pipe #(
		.LANES (1),
		.NUM_W (DVD_W),
		.DEN_W (DEN_W),
		.QUO_W (QD)
	) u_avg_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s4),
		.in_num    (dvd_s4),
		.in_den    (den_s4),
		.out_valid (q_valid),
		.out_quo   (quo_d)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			neg_d[0] <= neg_s4;
			for (int k = 1; k < QD; k++)
				neg_d[k] <= neg_d[k-1];
		end
	end

	always_comb begin
		drive_c = neg_d[QD-1] ? -quo_d : quo_d;
		if (quo_d == '0)
			dir_c = ftc_pkg::DIR_IDLE;
		else if (neg_d[QD-1])
			dir_c = ftc_pkg::DIR_COOL;
		else
			dir_c = ftc_pkg::DIR_HEAT;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else if (en)
			valid_q <= q_valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			drive_q <= drive_c;
			dir_q   <= dir_c;
		end
	end

	assign out_valid = valid_q;
	assign out_drive = drive_q;
	assign out_dir   = dir_q;

endmodule
